@@ rtl/pmat_pkg.sv @@
// ----------------------------------------------------------------------------
// pmat_pkg
// shared types, sizes and codes of the page migration access tracker
// ----------------------------------------------------------------------------
package pmat_pkg;

    // table geometry; PAGES and MAX_GPUS are powers of two
    localparam int PAGES            = 1024;
    localparam int MAX_GPUS         = 4;
    localparam int COUNTER_BITS     = 16;
    localparam int FETCHES_PER_PAGE = 32;

    // fixed field widths
    localparam int MODE_BITS    = 3;
    localparam int PAGE_IN_BITS = 10;
    localparam int GPU_IN_BITS  = 2;
    localparam int THR_BITS     = 16;
    localparam int GPUS_BITS    = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 16;

    // derived widths
    localparam int PAGE_BITS = $clog2(PAGES);
    localparam int GPU_BITS  = $clog2(MAX_GPUS);
    localparam int WB_BITS   = $clog2(FETCHES_PER_PAGE + 1);
    localparam int SUM_BITS  = ((COUNTER_BITS > THR_BITS) ? COUNTER_BITS : THR_BITS) + 1;
    localparam int GM_BITS   = PAGE_BITS + GPU_BITS;

    // event codes
    localparam logic [MODE_BITS-1:0] MODE_READ     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_WRITE    = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_WB       = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_AGREE_RO = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_AGREE_WR = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_QUERY    = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GPUS      = 2'd1;

    localparam logic [THR_BITS-1:0]  THR_RESET  = 16'd16;
    localparam logic [GPUS_BITS-1:0] GPUS_RESET = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP,
        ST_INIT,
        ST_FINISH
    } t_state;

    // per page word
    typedef struct packed {
        logic               valid;
        logic               ws;
        logic [WB_BITS-1:0] wb;
    } t_page_word;

    // per page and requester word
    typedef struct packed {
        logic                    mark;
        logic [COUNTER_BITS-1:0] wcnt;
        logic [COUNTER_BITS-1:0] rcnt;
    } t_gpu_word;

    function automatic logic [PAGE_BITS-1:0] page_index(input logic [PAGE_IN_BITS-1:0] p);
        return PAGE_BITS'(32'(p) % PAGES);
    endfunction

    function automatic logic [GPU_BITS-1:0] gpu_index(input logic [GPU_IN_BITS-1:0] g);
        return GPU_BITS'(32'(g) % MAX_GPUS);
    endfunction

    // index of the last requester that takes part
    function automatic logic [GPU_BITS-1:0] last_gpu(input logic [GPUS_BITS-1:0] n);
        logic [GPU_BITS-1:0] res;
        if (n == '0) begin
            res = '0;
        end else if (32'(n) > MAX_GPUS) begin
            res = GPU_BITS'(MAX_GPUS - 1);
        end else begin
            res = GPU_BITS'(32'(n) - 1);
        end
        return res;
    endfunction

    function automatic logic [COUNTER_BITS-1:0] bump(input logic [COUNTER_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

endpackage

@@ rtl/page_migration_access_tracker.sv @@
// ----------------------------------------------------------------------------
// page_migration_access_tracker
// per-page requester counters and migration eligibility
// ----------------------------------------------------------------------------
// Events enter on the input channel (i_in_valid / o_in_ready) with mode,
// page number and requester; each beat gives exactly one result beat on the
// output channel (o_out_valid / i_out_ready). Registers are written through
// the configuration channel, which is always ready.
// Paths of an item, from accept to the next accept:
//   read / write / write-back / read-only agree on a tracked page: look, finish
//   entry initialization (first event, writable agree, write-back wrap):
//     every requester word of the entry cleared, one written per cycle
//   query: active requesters swept, one requester word read per cycle from the
//     single port of the requester memory into the shared compare unit
// The result enters an output register; the block takes the next beat while
// it waits. If the receiver stalls and a second result is ready, the block
// holds it and stays not ready until the register frees.
// After reset a clearing pass over all PAGES (1024) page words wipes the page
// memory; input beats are not accepted meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
module page_migration_access_tracker
    import pmat_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [MODE_BITS-1:0]    i_mode,
    input  logic [PAGE_IN_BITS-1:0] i_page_number,
    input  logic [GPU_IN_BITS-1:0]  i_gpu_id,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_readonly_ok,
    output logic                    o_writable_ok,
    output logic                    o_already_shared,
    output logic                    o_page_reset,
    output logic                    o_error,
    // configuration channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DAT_BITS-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [MODE_BITS-1:0] r_mode;
    logic [PAGE_BITS-1:0] r_pg;
    logic [GPU_BITS-1:0]  r_g;
    logic [GPU_BITS-1:0]  r_idx, n_idx;
    logic [PAGE_BITS-1:0] r_clr, n_clr;
    logic                 r_valid, n_valid;
    logic [COUNTER_BITS-1:0] r_own_w, n_own_w;
    logic r_ro, n_ro, r_wr, n_wr, r_sh, n_sh, r_rst, n_rst, r_err, n_err;

    logic [THR_BITS-1:0]  r_thr;
    logic [GPUS_BITS-1:0] r_gpus;

    logic r_out_valid;
    logic r_o_ro, r_o_wr, r_o_sh, r_o_rst, r_o_err;

    // memories
    t_page_word page_mem [PAGES];
    t_gpu_word  gpu_mem  [PAGES*MAX_GPUS];
    t_page_word r_pw;
    t_gpu_word  r_gw;

    logic                 pg_we;
    logic [PAGE_BITS-1:0] pg_wa;
    t_page_word           pg_wd;
    logic [PAGE_BITS-1:0] pg_ra;
    logic                 gm_we;
    logic [GM_BITS-1:0]   gm_wa;
    t_gpu_word            gm_wd;
    logic [GM_BITS-1:0]   gm_ra;

    logic                    in_acc;
    logic                    load_out;
    logic [GPU_BITS-1:0]     last;
    logic [WB_BITS:0]        wb_next;
    logic [COUNTER_BITS-1:0] cmp_a, cmp_b;
    logic [COUNTER_BITS-1:0] sw_r, sw_w;
    logic                    cmp_gt;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign load_out    = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    assign last        = last_gpu(r_gpus);
    assign wb_next     = (WB_BITS + 1)'(r_pw.wb) + 1'b1;

    // sweep operands, masked for an untracked page
    assign sw_r = r_valid ? r_gw.rcnt : '0;
    assign sw_w = r_valid ? r_gw.wcnt : '0;

    // shared compare operands
    assign cmp_a = (r_state == ST_SWEEP) ? r_own_w : (r_pw.valid ? r_gw.rcnt : '0);
    assign cmp_b = (r_state == ST_SWEEP) ? sw_r : '0;

    pmat_cmp_unit u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .i_thr (r_thr),
        .o_gt  (cmp_gt)
    );

    // read addresses: input beat while idle, else the latched page
    assign pg_ra = (r_state == ST_IDLE) ? page_index(i_page_number) : r_pg;
    always_comb begin
        if (r_state == ST_IDLE) begin
            gm_ra = {page_index(i_page_number), gpu_index(i_gpu_id)};
        end else if (r_state == ST_SWEEP) begin
            gm_ra = {r_pg, r_idx + 1'b1};
        end else begin
            gm_ra = {r_pg, {GPU_BITS{1'b0}}};
        end
    end

    // page memory
    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            page_mem[pg_wa] <= pg_wd;
        end
        r_pw <= page_mem[pg_ra];
    end

    // requester memory
    always_ff @(posedge i_clk) begin
        if (gm_we) begin
            gpu_mem[gm_wa] <= gm_wd;
        end
        r_gw <= gpu_mem[gm_ra];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_pg   <= page_index(i_page_number);
            r_g    <= gpu_index(i_gpu_id);
        end
        r_idx   <= n_idx;
        r_valid <= n_valid;
        r_own_w <= n_own_w;
        r_ro    <= n_ro;
        r_wr    <= n_wr;
        r_sh    <= n_sh;
        r_rst   <= n_rst;
        r_err   <= n_err;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_gpus <= GPUS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr  <= i_cfg_data[THR_BITS-1:0];
                CFG_GPUS:      r_gpus <= i_cfg_data[GPUS_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_ro  <= r_ro;
            r_o_wr  <= r_wr;
            r_o_sh  <= r_sh;
            r_o_rst <= r_rst;
            r_o_err <= r_err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_readonly_ok    = r_o_ro;
    assign o_writable_ok    = r_o_wr;
    assign o_already_shared = r_o_sh;
    assign o_page_reset     = r_o_rst;
    assign o_error          = r_o_err;

    // sequencer: next state, memory writes and result bits
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_idx   = r_idx;
        n_valid = r_valid;
        n_own_w = r_own_w;
        n_ro    = r_ro;
        n_wr    = r_wr;
        n_sh    = r_sh;
        n_rst   = r_rst;
        n_err   = r_err;
        pg_we   = 1'b0;
        pg_wa   = r_pg;
        pg_wd   = '{valid: 1'b1, ws: 1'b0, wb: '0};
        gm_we   = 1'b0;
        gm_wa   = {r_pg, r_g};
        gm_wd   = r_gw;
        case (r_state)
            // wipe page words after reset
            ST_CLEAR: begin
                pg_we = 1'b1;
                pg_wa = r_clr;
                pg_wd = '{valid: 1'b0, ws: 1'b0, wb: '0};
                n_clr = r_clr + 1'b1;
                if (r_clr == PAGE_BITS'(PAGES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_ro    = 1'b0;
                    n_wr    = 1'b0;
                    n_sh    = 1'b0;
                    n_rst   = 1'b0;
                    n_err   = 1'b0;
                    n_state = ST_LOOK;
                end
            end
            // page word and own requester word are in
            ST_LOOK: begin
                n_valid = r_pw.valid;
                n_idx   = '0;
                n_state = ST_FINISH;
                case (r_mode)
                    MODE_READ, MODE_WRITE, MODE_WB: begin
                        if (!r_pw.valid) begin
                            pg_we   = 1'b1;
                            n_state = ST_INIT;
                        end else if (r_mode == MODE_READ) begin
                            gm_we      = 1'b1;
                            gm_wd.rcnt = bump(r_gw.rcnt);
                            n_sh       = r_gw.mark;
                        end else if (r_mode == MODE_WRITE) begin
                            gm_we      = 1'b1;
                            gm_wd.wcnt = bump(r_gw.wcnt);
                            n_sh       = r_gw.mark;
                        end else if (32'(wb_next) >= FETCHES_PER_PAGE) begin
                            pg_we   = 1'b1;
                            n_rst   = 1'b1;
                            n_state = ST_INIT;
                        end else begin
                            pg_we = 1'b1;
                            pg_wd = '{valid: 1'b1, ws: r_pw.ws, wb: wb_next[WB_BITS-1:0]};
                            n_sh  = r_gw.mark;
                        end
                    end
                    MODE_AGREE_RO: begin
                        if (!r_pw.valid) begin
                            n_err = 1'b1;
                        end else begin
                            gm_we      = 1'b1;
                            gm_wd.mark = 1'b1;
                            n_sh       = 1'b1;
                        end
                    end
                    MODE_AGREE_WR: begin
                        if (!r_pw.valid) begin
                            n_err = 1'b1;
                        end else begin
                            pg_we    = 1'b1;
                            pg_wd.ws = 1'b1;
                            n_sh     = 1'b1;
                            n_state  = ST_INIT;
                        end
                    end
                    MODE_QUERY: begin
                        n_ro    = cmp_gt;
                        n_wr    = 1'b1;
                        n_own_w = r_pw.valid ? r_gw.wcnt : '0;
                        n_sh    = r_pw.valid && r_gw.mark;
                        n_state = ST_SWEEP;
                    end
                    default: ;
                endcase
            end
            // one requester word per cycle through the compare unit
            ST_SWEEP: begin
                if (sw_w != '0) begin
                    n_ro = 1'b0;
                end
                if (r_idx != r_g) begin
                    if (!cmp_gt || (sw_w != '0)) begin
                        n_wr = 1'b0;
                    end
                end
                if (r_idx == last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // clear requester words of the entry; a writable agree sets its own mark
            ST_INIT: begin
                gm_we      = 1'b1;
                gm_wa      = {r_pg, r_idx};
                gm_wd      = '0;
                gm_wd.mark = (r_mode == MODE_AGREE_WR) && (r_idx == r_g);
                if (r_idx == GPU_BITS'(MAX_GPUS - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/pmat_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// pmat_cmp_unit
// shared add and compare: a > b + threshold, formed without wrap
// ----------------------------------------------------------------------------
module pmat_cmp_unit
    import pmat_pkg::*;
(
    input  logic [COUNTER_BITS-1:0] i_a,
    input  logic [COUNTER_BITS-1:0] i_b,
    input  logic [THR_BITS-1:0]     i_thr,
    output logic                    o_gt
);

    logic [SUM_BITS-1:0] sum;

    // widened sum then compare
    assign sum  = SUM_BITS'(i_b) + SUM_BITS'(i_thr);
    assign o_gt = SUM_BITS'(i_a) > sum;

endmodule

@@ rtl/pmat_checker.sv @@
// ----------------------------------------------------------------------------
// pmat_checker
// port-level checks of the access tracker, bound to the top level
// ----------------------------------------------------------------------------
module pmat_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_readonly_ok,
    input logic o_writable_ok,
    input logic o_already_shared,
    input logic o_page_reset,
    input logic o_error
);

    // stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_readonly_ok)
            && $stable(o_writable_ok) && $stable(o_already_shared)
            && $stable(o_page_reset) && $stable(o_error))
        else $error("result beat changed while stalled");

    // an ignored agree reports nothing else
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> !o_readonly_ok && !o_writable_ok
            && !o_already_shared && !o_page_reset)
        else $error("error beat carries other flags");

    // a completed write-back leaves a cleared entry
    a_reset_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_page_reset |-> !o_readonly_ok && !o_writable_ok
            && !o_already_shared)
        else $error("page reset beat carries other flags");

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block ready right after reset");

endmodule

bind page_migration_access_tracker pmat_checker u_pmat_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_readonly_ok    (o_readonly_ok),
    .o_writable_ok    (o_writable_ok),
    .o_already_shared (o_already_shared),
    .o_page_reset     (o_page_reset),
    .o_error          (o_error)
);
